@@ hw/rtl/heavy_hitter_counter_table_unit_assert.svh @@
// Assertion macros for the heavy hitter counter table
`ifndef HEAVY_HITTER_COUNTER_TABLE_UNIT_ASSERT_SVH
`define HEAVY_HITTER_COUNTER_TABLE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define HHCT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("hhct assertion failed");
`define HHCT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("hhct assertion failed");
`else
`define HHCT_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define HHCT_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ hw/rtl/hhct_pkg.sv @@
`default_nettype none
package hhct_pkg;

  localparam int EST_W    = 48;
  localparam int WEIGHT_W = 16;
  localparam logic [EST_W-1:0] EST_MAX = {EST_W{1'b1}};

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  localparam logic [1:0] ST_EMPTY = 2'd0;
  localparam logic [1:0] ST_LIVE  = 2'd1;
  localparam logic [1:0] ST_EXTRA = 2'd2;

  localparam logic [2:0] OUT_HIT  = 3'd0;
  localparam logic [2:0] OUT_NEW  = 3'd1;
  localparam logic [2:0] OUT_KEPT = 3'd2;
  localparam logic [2:0] OUT_DROP = 3'd3;
  localparam logic [2:0] OUT_DONE = 3'd4;

endpackage
`default_nettype wire

@@ hw/rtl/heavy_hitter_counter_table_unit.sv @@
// channel | direction | handshake              | payload
// in_     | input     | in_valid / in_ready    | kind, item_key, item_weight, slot_index
// out_    | output    | out_valid / out_ready  | outcome, key, estimate, state, total, live
// cfg_    | input     | cfg_wr_en              | buckets_in_use
// Insert: one pass over slots 0..k-1 through the key/count memory read port
// for a hit or a free slot; a miss on a full table adds a second subtract-and-trim
// pass through the same port. A read uses the port once; a clear takes no pass.
// One word in flight; the next word is taken while a result waits at out_.
// in_ready is low during a register write. out_ready low only holds the result state.
// Synchronous active-low reset empties every slot, zeroes the total, k = 64.
`default_nettype none
`include "heavy_hitter_counter_table_unit_assert.svh"

module heavy_hitter_counter_table_unit #(
  parameter int MAX_SLOTS  = 64,
  parameter int KEY_BITS   = 64,
  parameter int COUNT_BITS = 40
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_kind,
  input  wire logic [63:0] in_item_key,
  input  wire logic [15:0] in_item_weight,
  input  wire logic [5:0]  in_slot_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_insert_outcome,
  output logic [63:0]      out_slot_key,
  output logic [47:0]      out_slot_estimate,
  output logic [1:0]       out_slot_state,
  output logic [47:0]      out_total_decrement_out,
  output logic [6:0]       out_live_slots,
  input  wire logic        cfg_wr_en,
  input  wire logic [6:0]  cfg_wr_data
);

  localparam int IW    = $clog2(MAX_SLOTS);
  localparam int KW    = $clog2(MAX_SLOTS + 1);
  localparam int CW    = COUNT_BITS;
  localparam int EW    = hhct_pkg::EST_W;
  localparam int WW    = hhct_pkg::WEIGHT_W;
  localparam int SUMW  = ((CW > EW) ? CW : EW) + 1;
  localparam int K_RST = (MAX_SLOTS < 64) ? MAX_SLOTS : 64;
  localparam logic [CW-1:0] COUNT_MAX = {CW{1'b1}};

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_DEC, S_PLACE, S_RDA, S_RDB, S_RESP
  } state_t;

  state_t              state_r;
  logic [KEY_BITS-1:0] key_mem [MAX_SLOTS];
  logic [CW-1:0]       cnt_mem [MAX_SLOTS];
  logic [1:0]          status_r [MAX_SLOTS];

  logic [1:0]          kind_r;
  logic [KEY_BITS-1:0] key_r;
  logic [WW-1:0]       w_r;
  logic [IW-1:0]       sidx_r;
  logic                sidx_ok_r;
  logic [KW-1:0]       k_r, live_r, a_r;
  logic [EW-1:0]       td_r;
  logic                pv_r;
  logic [IW-1:0]       pi_r;
  logic [KEY_BITS-1:0] rd_key_r;
  logic [CW-1:0]       rd_cnt_r;

  logic                hit_f_r, xm_f_r, em_f_r, hx_f_r;
  logic [IW-1:0]       hit_i_r, xm_i_r, em_i_r, hx_i_r;
  logic [CW-1:0]       hit_c_r, min_r;
  logic [KW-1:0]       nmin_r, lafter_r, allow_r, kept_r;
  logic [WW-1:0]       m_r, r_r;

  logic [2:0]          res_outc_r;
  logic [KEY_BITS-1:0] res_key_r;
  logic [CW-1:0]       res_cnt_r;
  logic [1:0]          res_st_r;

  logic                out_valid_r;
  logic [2:0]          out_outc_r;
  logic [63:0]         out_key_r;
  logic [EW-1:0]       out_est_r, out_td_r;
  logic [1:0]          out_st_r;
  logic [6:0]          out_live_r;

  // combinational helpers
  logic                issue;
  logic [IW-1:0]       rd_addr;
  logic [1:0]          pst;
  logic [CW:0]         hit_sum;
  logic [CW-1:0]       hit_new;
  logic                tgt_ok;
  logic [IW-1:0]       tgt_i;
  logic [WW-1:0]       r_c;
  logic [KW-1:0]       la0, la1;
  logic [CW-1:0]       nc;
  logic                post_empty, keep_extra;
  logic                place_ok;
  logic [SUMW-1:0]     est_sum;
  logic [EW-1:0]       est_sat;
  logic [EW:0]         td_sum;
  logic                kw_en, cw_en;
  logic [IW-1:0]       kw_addr, cw_addr;
  logic [KEY_BITS-1:0] kw_data;
  logic [CW-1:0]       cw_data;

  assign in_ready = (state_r == S_IDLE) && !cfg_wr_en;
  assign issue    = (state_r == S_SCAN || state_r == S_DEC) && (a_r < k_r);
  assign rd_addr  = (state_r == S_RDA) ? sidx_r : a_r[IW-1:0];
  assign pst      = status_r[pi_r];

  assign hit_sum = {1'b0, hit_c_r} + (CW+1)'(w_r);
  assign hit_new = hit_sum[CW] ? COUNT_MAX : hit_sum[CW-1:0];

  // free-slot choice: extra with same key, else lowest empty, else highest extra
  always_comb begin
    tgt_ok = 1'b1;
    tgt_i  = xm_i_r;
    priority if (xm_f_r) tgt_i = xm_i_r;
    else if (em_f_r)     tgt_i = em_i_r;
    else if (hx_f_r)     tgt_i = hx_i_r;
    else                 tgt_ok = 1'b0;
  end

  assign r_c = w_r - min_r[WW-1:0];
  assign la0 = live_r - nmin_r;
  assign la1 = la0 + KW'(r_c != '0);

  assign nc         = rd_cnt_r - CW'(m_r);
  assign keep_extra = (kept_r < allow_r);
  assign post_empty = (pst == hhct_pkg::ST_EMPTY) || (pst == hhct_pkg::ST_EXTRA) ||
                      ((pst == hhct_pkg::ST_LIVE) && (nc == '0) && !keep_extra);
  assign place_ok   = em_f_r && ((r_r != '0) || keep_extra);

  assign est_sum = SUMW'(res_cnt_r) + SUMW'(td_r);
  assign est_sat = (est_sum > SUMW'(hhct_pkg::EST_MAX)) ? hhct_pkg::EST_MAX
                                                         : est_sum[EW-1:0];
  assign td_sum  = {1'b0, td_r} + (EW+1)'(m_r);

  always_comb begin
    kw_en   = 1'b0;
    kw_addr = tgt_i;
    kw_data = key_r;
    cw_en   = 1'b0;
    cw_addr = tgt_i;
    cw_data = CW'(w_r);
    unique case (state_r)
      S_DECIDE: begin
        if (hit_f_r) begin
          cw_en   = 1'b1;
          cw_addr = hit_i_r;
          cw_data = hit_new;
        end else if (w_r != '0 && live_r < k_r && tgt_ok) begin
          kw_en = 1'b1;
          cw_en = 1'b1;
        end
      end
      S_DEC: begin
        if (pv_r && pst == hhct_pkg::ST_LIVE) begin
          cw_en   = 1'b1;
          cw_addr = pi_r;
          cw_data = nc;
        end
      end
      S_PLACE: begin
        kw_addr = em_i_r;
        cw_addr = em_i_r;
        cw_data = CW'(r_r);
        kw_en   = place_ok;
        cw_en   = place_ok;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (kw_en) key_mem[kw_addr] <= kw_data;
    if (cw_en) cnt_mem[cw_addr] <= cw_data;
    rd_key_r <= key_mem[rd_addr];
    rd_cnt_r <= cnt_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= KW'(K_RST);
      live_r      <= '0;
      td_r        <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_SLOTS; i++) status_r[i] <= hhct_pkg::ST_EMPTY;
    end else begin
      pv_r <= issue;
      if (issue) begin
        pi_r <= a_r[IW-1:0];
        a_r  <= a_r + KW'(1);
      end
      if (out_valid_r && out_ready && state_r != S_RESP) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            kind_r    <= in_kind;
            key_r     <= in_item_key[KEY_BITS-1:0];
            w_r       <= in_item_weight;
            sidx_r    <= IW'(in_slot_index);
            sidx_ok_r <= (32'(in_slot_index) < MAX_SLOTS);
            a_r       <= '0;
            hit_f_r   <= 1'b0;
            xm_f_r    <= 1'b0;
            em_f_r    <= 1'b0;
            hx_f_r    <= 1'b0;
            min_r     <= CW'(in_item_weight);
            nmin_r    <= '0;
            res_outc_r <= hhct_pkg::OUT_DONE;
            res_key_r  <= '0;
            res_cnt_r  <= '0;
            res_st_r   <= hhct_pkg::ST_EMPTY;
            unique case (in_kind)
              hhct_pkg::KIND_INSERT: state_r <= S_SCAN;
              hhct_pkg::KIND_READ:   state_r <= S_RDA;
              hhct_pkg::KIND_CLEAR: begin
                for (int i = 0; i < MAX_SLOTS; i++) status_r[i] <= hhct_pkg::ST_EMPTY;
                td_r    <= '0;
                live_r  <= '0;
                state_r <= S_RESP;
              end
              default: state_r <= S_RESP;
            endcase
          end
        end

        S_SCAN: begin
          if (pv_r) begin
            if (pst == hhct_pkg::ST_LIVE) begin
              if (rd_key_r == key_r && !hit_f_r) begin
                hit_f_r <= 1'b1;
                hit_i_r <= pi_r;
                hit_c_r <= rd_cnt_r;
              end
              // track the minimum and how many live slots sit at it
              if (rd_cnt_r < min_r) begin
                min_r  <= rd_cnt_r;
                nmin_r <= KW'(1);
              end else if (rd_cnt_r == min_r) begin
                nmin_r <= nmin_r + KW'(1);
              end
            end
            if (pst == hhct_pkg::ST_EXTRA) begin
              if (rd_key_r == key_r && !xm_f_r) begin
                xm_f_r <= 1'b1;
                xm_i_r <= pi_r;
              end
              hx_f_r <= 1'b1;
              hx_i_r <= pi_r;
            end
            if (pst == hhct_pkg::ST_EMPTY && !em_f_r) begin
              em_f_r <= 1'b1;
              em_i_r <= pi_r;
            end
          end
          if (!issue && !pv_r) state_r <= S_DECIDE;
        end

        S_DECIDE: begin
          res_key_r <= key_r;
          state_r   <= S_RESP;
          if (hit_f_r) begin
            res_outc_r <= hhct_pkg::OUT_HIT;
            res_cnt_r  <= hit_new;
            res_st_r   <= hhct_pkg::ST_LIVE;
          end else if (w_r == '0) begin
            res_outc_r <= hhct_pkg::OUT_DROP;
          end else if (live_r < k_r) begin
            if (tgt_ok) begin
              status_r[tgt_i] <= hhct_pkg::ST_LIVE;
              live_r     <= live_r + KW'(1);
              res_outc_r <= hhct_pkg::OUT_NEW;
              res_cnt_r  <= CW'(w_r);
              res_st_r   <= hhct_pkg::ST_LIVE;
            end else begin
              res_outc_r <= hhct_pkg::OUT_DROP;
            end
          end else begin
            m_r      <= min_r[WW-1:0];
            r_r      <= r_c;
            lafter_r <= la0;
            allow_r  <= (k_r > la1) ? k_r - la1 : '0;
            kept_r   <= '0;
            em_f_r   <= 1'b0;
            a_r      <= '0;
            state_r  <= S_DEC;
          end
        end

        S_DEC: begin
          if (pv_r) begin
            if (pst == hhct_pkg::ST_EXTRA) begin
              status_r[pi_r] <= hhct_pkg::ST_EMPTY;
            end else if (pst == hhct_pkg::ST_LIVE && nc == '0) begin
              // zeroed slots stay as extras while the allowance lasts, lowest indices first
              if (keep_extra) begin
                status_r[pi_r] <= hhct_pkg::ST_EXTRA;
                kept_r <= kept_r + KW'(1);
              end else begin
                status_r[pi_r] <= hhct_pkg::ST_EMPTY;
              end
            end
            if (post_empty && !em_f_r) begin
              em_f_r <= 1'b1;
              em_i_r <= pi_r;
            end
          end
          if (!issue && !pv_r) state_r <= S_PLACE;
        end

        S_PLACE: begin
          td_r    <= td_sum[EW] ? hhct_pkg::EST_MAX : td_sum[EW-1:0];
          state_r <= S_RESP;
          if (place_ok) begin
            status_r[em_i_r] <= (r_r != '0) ? hhct_pkg::ST_LIVE : hhct_pkg::ST_EXTRA;
            live_r     <= lafter_r + KW'(r_r != '0);
            res_outc_r <= hhct_pkg::OUT_KEPT;
            res_cnt_r  <= CW'(r_r);
            res_st_r   <= (r_r != '0) ? hhct_pkg::ST_LIVE : hhct_pkg::ST_EXTRA;
          end else begin
            live_r     <= lafter_r;
            res_outc_r <= hhct_pkg::OUT_DROP;
          end
        end

        S_RDA: state_r <= S_RDB;

        S_RDB: begin
          if (sidx_ok_r && status_r[sidx_r] != hhct_pkg::ST_EMPTY) begin
            res_key_r <= rd_key_r;
            res_st_r  <= status_r[sidx_r];
            res_cnt_r <= (status_r[sidx_r] == hhct_pkg::ST_LIVE) ? rd_cnt_r : '0;
          end
          state_r <= S_RESP;
        end

        S_RESP: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_outc_r  <= res_outc_r;
            out_key_r   <= 64'(res_key_r);
            out_est_r   <= (res_st_r == hhct_pkg::ST_EMPTY) ? '0 : est_sat;
            out_st_r    <= res_st_r;
            out_td_r    <= td_r;
            out_live_r  <= 7'(live_r);
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase

      // register write resizes and empties the table
      if (cfg_wr_en) begin
        if (cfg_wr_data == '0)                k_r <= KW'(1);
        else if (32'(cfg_wr_data) > MAX_SLOTS) k_r <= KW'(MAX_SLOTS);
        else                                  k_r <= KW'(cfg_wr_data);
        for (int i = 0; i < MAX_SLOTS; i++) status_r[i] <= hhct_pkg::ST_EMPTY;
        td_r   <= '0;
        live_r <= '0;
      end
    end
  end

  assign out_valid               = out_valid_r;
  assign out_insert_outcome      = out_outc_r;
  assign out_slot_key            = out_key_r;
  assign out_slot_estimate       = out_est_r;
  assign out_slot_state          = out_st_r;
  assign out_total_decrement_out = out_td_r;
  assign out_live_slots          = out_live_r;

  `HHCT_ASSERT_IMP(a_live_within_k, clk, rst_n, 1'b1, live_r <= k_r)
  `HHCT_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  `HHCT_ASSERT_IMP(a_hit_is_live, clk, rst_n,
                   out_valid && out_insert_outcome == hhct_pkg::OUT_HIT,
                   out_slot_state == hhct_pkg::ST_LIVE)
  `HHCT_ASSERT_IMP(a_dec_step_le_weight, clk, rst_n, state_r == S_DEC, m_r <= w_r)

endmodule
`default_nettype wire

@@ tb/tb_heavy_hitter_counter_table_unit.sv @@
`timescale 1ns / 100ps
`default_nettype none

module tb_heavy_hitter_counter_table_unit;

  localparam int NSLOT = 64;
  localparam longint unsigned CNT_MAX = (64'd1 << 40) - 1;
  localparam longint unsigned TOT_MAX = (64'd1 << 48) - 1;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    logic [2:0]  outcome;
    logic [63:0] key;
    logic [47:0] est;
    logic [1:0]  state;
    logic [47:0] total;
    logic [6:0]  live;
  } table_word_t;

  // Misra-Gries table mirror plus the queue of words it has predicted
  class hitter_table_sb;
    logic [63:0]     keys[NSLOT];
    longint unsigned cnts[NSLOT];
    logic [1:0]      stat[NSLOT];
    longint unsigned total;
    int              k;
    table_word_t     pending[$];
    int              errors;

    function new();
      k = NSLOT;
      errors = 0;
      wipe();
    endfunction

    function void wipe();
      for (int i = 0; i < NSLOT; i++) begin
        keys[i] = '0;
        cnts[i] = 0;
        stat[i] = hhct_pkg::ST_EMPTY;
      end
      total = 0;
    endfunction

    function void set_size(logic [6:0] v);
      k = (v < 1) ? 1 : (v > NSLOT) ? NSLOT : int'(v);
      wipe();
    endfunction

    function int live_count();
      int n;
      n = 0;
      for (int i = 0; i < NSLOT; i++) if (stat[i] == hhct_pkg::ST_LIVE) n++;
      return n;
    endfunction

    function void slot_fields(int s, ref table_word_t w);
      longint unsigned sum;
      if (stat[s] == hhct_pkg::ST_EMPTY) begin
        w.key = '0; w.est = '0; w.state = hhct_pkg::ST_EMPTY;
        return;
      end
      w.key = keys[s];
      w.state = stat[s];
      sum = cnts[s] + total;
      if (stat[s] == hhct_pkg::ST_LIVE) w.est = 48'((sum > TOT_MAX) ? TOT_MAX : sum);
      else w.est = 48'(total);
    endfunction

    function int lowest_empty();
      for (int i = 0; i < k; i++) if (stat[i] == hhct_pkg::ST_EMPTY) return i;
      return -1;
    endfunction

    function void insert_word(logic [63:0] key, longint unsigned wt, ref table_word_t w);
      int hit, tgt, live_after, allowed, kept;
      longint unsigned m, r;
      hit = -1; tgt = -1; kept = 0;
      for (int i = 0; i < k; i++)
        if (hit < 0 && stat[i] == hhct_pkg::ST_LIVE && keys[i] == key) hit = i;
      if (hit >= 0) begin
        cnts[hit] = (cnts[hit] + wt > CNT_MAX) ? CNT_MAX : cnts[hit] + wt;
        w.outcome = hhct_pkg::OUT_HIT;
        slot_fields(hit, w);
        return;
      end
      w.outcome = hhct_pkg::OUT_DROP; w.key = key; w.est = '0;
      w.state = hhct_pkg::ST_EMPTY;
      if (wt == 0) return;
      if (live_count() < k) begin
        for (int i = 0; i < k; i++)
          if (tgt < 0 && stat[i] == hhct_pkg::ST_EXTRA && keys[i] == key) tgt = i;
        if (tgt < 0) tgt = lowest_empty();
        for (int i = k - 1; i >= 0; i--)
          if (tgt < 0 && stat[i] == hhct_pkg::ST_EXTRA) tgt = i;
        if (tgt < 0) return;
        keys[tgt] = key; cnts[tgt] = wt; stat[tgt] = hhct_pkg::ST_LIVE;
        w.outcome = hhct_pkg::OUT_NEW;
        slot_fields(tgt, w);
        return;
      end
      m = wt;
      for (int i = 0; i < k; i++)
        if (stat[i] == hhct_pkg::ST_LIVE && cnts[i] < m) m = cnts[i];
      total = (total + m > TOT_MAX) ? TOT_MAX : total + m;
      for (int i = 0; i < k; i++) begin
        if (stat[i] == hhct_pkg::ST_EXTRA) stat[i] = hhct_pkg::ST_EMPTY;
        else if (stat[i] == hhct_pkg::ST_LIVE) begin
          cnts[i] -= m;
          if (cnts[i] == 0) stat[i] = hhct_pkg::ST_EXTRA;
        end
      end
      r = wt - m;
      live_after = live_count() + ((r > 0) ? 1 : 0);
      allowed = (k > live_after) ? k - live_after : 0;
      // trim extras, lowest indices survive
      for (int i = 0; i < k; i++) begin
        if (stat[i] == hhct_pkg::ST_EXTRA) begin
          if (kept < allowed) kept++;
          else stat[i] = hhct_pkg::ST_EMPTY;
        end
      end
      tgt = lowest_empty();
      if (tgt >= 0 && (r > 0 || kept < allowed)) begin
        keys[tgt] = key; cnts[tgt] = r;
        stat[tgt] = (r > 0) ? hhct_pkg::ST_LIVE : hhct_pkg::ST_EXTRA;
        w.outcome = hhct_pkg::OUT_KEPT;
        slot_fields(tgt, w);
      end
    endfunction

    function void note_input(logic [1:0] kind, logic [63:0] key, logic [15:0] wt,
                             logic [5:0] idx);
      table_word_t w;
      w.outcome = hhct_pkg::OUT_DONE; w.key = '0; w.est = '0;
      w.state = hhct_pkg::ST_EMPTY;
      if (kind == hhct_pkg::KIND_INSERT) insert_word(key, 64'(wt), w);
      else if (kind == hhct_pkg::KIND_READ) slot_fields(int'(idx), w);
      else if (kind == hhct_pkg::KIND_CLEAR) wipe();
      w.total = 48'(total);
      w.live = 7'(live_count());
      pending = {pending, w};
    endfunction

    function void check_result(table_word_t got);
      table_word_t exp;
      if (pending.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.outcome !== exp.outcome) begin
        $error("insert_outcome exp %0d got %0d", exp.outcome, got.outcome); errors++;
      end
      if (got.key !== exp.key) begin
        $error("slot_key exp %h got %h", exp.key, got.key); errors++;
      end
      if (got.est !== exp.est) begin
        $error("slot_estimate exp %0d got %0d", exp.est, got.est); errors++;
      end
      if (got.state !== exp.state) begin
        $error("slot_state exp %0d got %0d", exp.state, got.state); errors++;
      end
      if (got.total !== exp.total) begin
        $error("total_decrement_out exp %0d got %0d", exp.total, got.total); errors++;
      end
      if (got.live !== exp.live) begin
        $error("live_slots exp %0d got %0d", exp.live, got.live); errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_kind = '0;
  logic [63:0] in_item_key = '0;
  logic [15:0] in_item_weight = '0;
  logic [5:0]  in_slot_index = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_insert_outcome;
  logic [63:0] out_slot_key;
  logic [47:0] out_slot_estimate;
  logic [1:0]  out_slot_state;
  logic [47:0] out_total_decrement_out;
  logic [6:0]  out_live_slots;
  logic        cfg_wr_en = 1'b0;
  logic [6:0]  cfg_wr_data = '0;

  hitter_table_sb sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic [63:0] key_pool[16];
  int pool_n;

  heavy_hitter_counter_table_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_kind(in_kind), .in_item_key(in_item_key),
    .in_item_weight(in_item_weight), .in_slot_index(in_slot_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_insert_outcome(out_insert_outcome), .out_slot_key(out_slot_key),
    .out_slot_estimate(out_slot_estimate), .out_slot_state(out_slot_state),
    .out_total_decrement_out(out_total_decrement_out), .out_live_slots(out_live_slots),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  initial begin
    #20_000_000;
    $display("heavy_hitter_counter_table_unit regression: fail");
    $finish;
  end

  // result side: random back-pressure, check on every accepted word
  always @(posedge clk) begin
    table_word_t got;
    if (rst_n && out_valid && out_ready) begin
      got.outcome = out_insert_outcome;
      got.key = out_slot_key;
      got.est = out_slot_estimate;
      got.state = out_slot_state;
      got.total = out_total_decrement_out;
      got.live = out_live_slots;
      sb.check_result(got);
    end
    out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_word(logic [1:0] kind, logic [63:0] key, logic [15:0] wt,
                           logic [5:0] idx);
    in_valid <= 1'b1;
    in_kind <= kind;
    in_item_key <= key;
    in_item_weight <= wt;
    in_slot_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(kind, key, wt, idx);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_size(logic [6:0] v);
    drain();
    repeat (140) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_size(v);
  endtask

  task automatic random_word();
    logic [63:0] key;
    logic [15:0] wt;
    int r;
    r = $urandom_range(99);
    key = ($urandom_range(3) != 0) ? key_pool[$urandom_range(pool_n - 1)]
                                   : {$urandom, $urandom};
    case ($urandom_range(3))
      0: wt = 16'hFFFF - 16'($urandom_range(3));
      1: wt = 16'($urandom_range(1, 65535));
      default: wt = 16'($urandom_range(1, 600));
    endcase
    if (r < 72) send_word(hhct_pkg::KIND_INSERT, key, wt, '0);
    else if (r < 94) send_word(hhct_pkg::KIND_READ, key, wt, 6'($urandom_range(63)));
    else if (r < 97) send_word(hhct_pkg::KIND_CLEAR, key, wt, 6'($urandom_range(63)));
    else send_word(KIND_UNUSED, key, wt, 6'($urandom_range(63)));
  endtask

  initial begin
    logic [6:0] sizes[8];
    sizes = '{7'd3, 7'd1, 7'd0, 7'd127, 7'd8, 7'd64, 7'd16, 7'd5};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset state readback, then small table for the decrement paths
    send_word(hhct_pkg::KIND_READ, '0, 16'd1, 6'd0);
    send_word(hhct_pkg::KIND_READ, '0, 16'd1, 6'd63);
    write_size(7'd2);
    send_word(hhct_pkg::KIND_INSERT, 64'h0, 16'd1, '0);
    send_word(hhct_pkg::KIND_INSERT, 64'h0, 16'hFFFF, '0);
    send_word(hhct_pkg::KIND_INSERT, '1, 16'd256, '0);
    // zero newcomer, no room
    send_word(hhct_pkg::KIND_INSERT, 64'h5555_AAAA_5555_AAAA, 16'd256, '0);
    send_word(hhct_pkg::KIND_READ, '0, 16'd1, 6'd1);
    send_word(hhct_pkg::KIND_INSERT, '1, 16'd5, '0);   // reuse extra of same key
    send_word(hhct_pkg::KIND_INSERT, 64'hAAAA_5555_AAAA_5555, 16'd3, '0);
    send_word(hhct_pkg::KIND_INSERT, 64'h0, 16'd0, '0);  // zero weight hit
    send_word(hhct_pkg::KIND_INSERT, 64'h1234, 16'd0, '0);  // zero weight miss
    send_word(hhct_pkg::KIND_INSERT, 64'h8000_0000_0000_0001, 16'd2, '0);
    send_word(hhct_pkg::KIND_INSERT, 64'h7FFF_FFFF_FFFF_FFFE, 16'd9, '0);
    send_word(hhct_pkg::KIND_READ, '0, 16'd1, 6'd0);
    send_word(hhct_pkg::KIND_READ, '0, 16'd1, 6'd1);
    send_word(hhct_pkg::KIND_READ, '0, 16'd1, 6'd63);
    send_word(KIND_UNUSED, '1, 16'hFFFF, 6'h3F);
    send_word(hhct_pkg::KIND_CLEAR, '0, 16'd1, '0);
    send_word(hhct_pkg::KIND_READ, '0, 16'd1, 6'd0);

    for (int ph = 0; ph < 8; ph++) begin
      write_size(sizes[ph]);
      pool_n = $urandom_range(2, 16);
      for (int i = 0; i < 16; i++) key_pool[i] = {$urandom, $urandom};
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 77; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 77; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      for (int n = 0; n < 66; n++) begin
        if (ph == 2 && n == 30) drain();
        random_word();
      end
    end

    drain();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("heavy_hitter_counter_table_unit regression: pass");
    else
      $display("heavy_hitter_counter_table_unit regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
